/* rtl/cpd_pkg.sv */
`timescale 1ns / 1ps
package cpd_pkg;

	localparam int CPD_COORD_BITS = 16;
	localparam int RADIUS_W       = 17;
	localparam int ANGLE_W        = 9;
	localparam int REG_IDX_W      = 1;

	// degree table and search
	localparam int DEG_N        = 90;
	localparam int DEG_W        = $clog2(DEG_N);
	localparam int SEARCH_STEPS = $clog2(DEG_N);
	localparam int ANG_LAT      = 3 * SEARCH_STEPS + 1;

	localparam logic [DEG_W-1:0]    DEG_LAST   = DEG_W'(DEG_N - 1);
	localparam logic [DEG_W-1:0]    DEG_DIAG   = DEG_W'(45);
	localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

	// quadrant codes, counter-clockwise from positive x
	typedef logic [1:0] quad_t;
	localparam quad_t QUAD_I   = 2'd0;
	localparam quad_t QUAD_II  = 2'd1;
	localparam quad_t QUAD_III = 2'd2;
	localparam quad_t QUAD_IV  = 2'd3;

	typedef struct packed {
		logic  zero;
		quad_t quad;
	} ang_tag_t;

	typedef logic [63:0] trig_tab_t [DEG_N];

	// q62 product
	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// sin / cos of whole degrees in q62, built by series then angle addition
	function automatic trig_tab_t build_tab(input logic want_sin);
		logic [63:0] x, x2, x3, x4, x5, x6, x7, x8;
		logic [63:0] s1, c1;
		trig_tab_t   st, ct;
		int          k;
		x  = 64'h3243F6A8885A308D / 64'd45;
		x2 = mulq(x, x);
		x3 = mulq(x2, x);
		x4 = mulq(x2, x2);
		x5 = mulq(x3, x2);
		x6 = mulq(x4, x2);
		x7 = mulq(x5, x2);
		x8 = mulq(x4, x4);
		s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
		c1 = 64'h4000_0000_0000_0000 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720
			+ x8 / 64'd40320;
		st[0] = 64'd0;
		ct[0] = 64'h4000_0000_0000_0000;
		for (k = 0; k < DEG_N - 1; k++) begin
			ct[k+1] = mulq(ct[k], c1) - mulq(st[k], s1);
			st[k+1] = mulq(st[k], c1) + mulq(ct[k], s1);
		end
		if (want_sin) begin
			return st;
		end
		return ct;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b1);
	localparam trig_tab_t COS_TAB = build_tab(1'b0);

endpackage

/* rtl/cpd_isqrt.sv */
`timescale 1ns / 1ps
module cpd_isqrt import cpd_pkg::*; #(
	parameter int IN_W   = 2 * CPD_COORD_BITS + 1,
	parameter int ROOT_W = CPD_COORD_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [IN_W-1:0]   in_val,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root
);

	localparam int T_W = (2 * ROOT_W + 1 > IN_W) ? 2 * ROOT_W + 1 : IN_W;

	logic              ch_vld  [ROOT_W+1];
	logic [IN_W-1:0]   ch_rem  [ROOT_W];
	logic [ROOT_W-1:0] ch_root [ROOT_W+1];

	assign ch_vld[0]  = in_vld;
	assign ch_rem[0]  = in_val;
	assign ch_root[0] = '0;

	// one root bit per stage, msb first
	for (genvar s = 0; s < ROOT_W; s++) begin : g_bit
		localparam int BIT = ROOT_W - 1 - s;
		logic [T_W-1:0]    trial;
		logic              fits;
		logic              vld_s1;
		logic [ROOT_W-1:0] root_s1;

		// (root + 2^bit)^2 - root^2, root has no bits at or below bit
		assign trial = (T_W'(ch_root[s]) << (BIT + 1)) | (T_W'(1) << (2 * BIT));
		assign fits  = T_W'(ch_rem[s]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= ch_vld[s];
			end
		end

		always_ff @(posedge clk) begin
			root_s1 <= fits ? (ch_root[s] | (ROOT_W'(1) << BIT)) : ch_root[s];
		end

		if (s < ROOT_W - 1) begin : g_rem
			logic [IN_W-1:0] rem_s1;
			always_ff @(posedge clk) begin
				rem_s1 <= fits ? IN_W'(T_W'(ch_rem[s]) - trial) : ch_rem[s];
			end
			assign ch_rem[s+1] = rem_s1;
		end

		assign ch_vld[s+1]  = vld_s1;
		assign ch_root[s+1] = root_s1;
	end

	assign out_vld  = ch_vld[ROOT_W];
	assign out_root = ch_root[ROOT_W];

endmodule

/* rtl/cpd_angle.sv */
`timescale 1ns / 1ps
module cpd_angle import cpd_pkg::*; #(
	parameter int MAG_W = CPD_COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [MAG_W-1:0]   in_a,
	input  logic [MAG_W-1:0]   in_b,
	input  ang_tag_t           in_tag,
	output logic               out_vld,
	output logic [ANGLE_W-1:0] out_angle
);

	localparam int PROD_W = MAG_W + 32;
	localparam int SUM_W  = MAG_W + 64;

	logic             st_vld [SEARCH_STEPS+1];
	logic [MAG_W-1:0] st_a   [SEARCH_STEPS];
	logic [MAG_W-1:0] st_b   [SEARCH_STEPS];
	logic [DEG_W-1:0] st_lo  [SEARCH_STEPS+1];
	logic [DEG_W-1:0] st_hi  [SEARCH_STEPS+1];
	ang_tag_t         st_tag [SEARCH_STEPS+1];

	assign st_vld[0] = in_vld;
	assign st_a[0]   = in_a;
	assign st_b[0]   = in_b;
	assign st_lo[0]  = '0;
	assign st_hi[0]  = DEG_LAST;
	assign st_tag[0] = in_tag;

	// each search step: multiply, sum partial products, compare and narrow
	for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
		logic [DEG_W:0]    mid_sum;
		logic [DEG_W-1:0]  mid;
		logic [63:0]       cos_k, sin_k;
		logic              beyond;

		logic              vld_s1, vld_s2, vld_s3;
		logic [MAG_W-1:0]  a_s1, b_s1, a_s2, b_s2;
		logic [DEG_W-1:0]  lo_s1, hi_s1, mid_s1, lo_s2, hi_s2, mid_s2, lo_s3, hi_s3;
		ang_tag_t          tag_s1, tag_s2, tag_s3;
		logic              diag_s1, bge_s1, diag_s2, bge_s2;
		logic [PROD_W-1:0] bch_s1, bcl_s1, ash_s1, asl_s1;
		logic [SUM_W-1:0]  lhs_s2, rhs_s2;

		assign mid_sum = {1'b0, st_lo[j]} + {1'b0, st_hi[j]} + (DEG_W+1)'(1);
		assign mid     = mid_sum[DEG_W:1];
		assign cos_k   = COS_TAB[mid];
		assign sin_k   = SIN_TAB[mid];

		// diagonal is decided on b >= a, off-diagonal on b*cos >= a*sin
		assign beyond = diag_s2 ? bge_s2 : (lhs_s2 >= rhs_s2);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				vld_s3 <= 1'b0;
			end else begin
				vld_s1 <= st_vld[j];
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
			end
		end

		always_ff @(posedge clk) begin
			a_s1    <= st_a[j];
			b_s1    <= st_b[j];
			lo_s1   <= st_lo[j];
			hi_s1   <= st_hi[j];
			mid_s1  <= mid;
			tag_s1  <= st_tag[j];
			diag_s1 <= mid == DEG_DIAG;
			bge_s1  <= st_b[j] >= st_a[j];
			bch_s1  <= PROD_W'(st_b[j]) * PROD_W'(cos_k[63:32]);
			bcl_s1  <= PROD_W'(st_b[j]) * PROD_W'(cos_k[31:0]);
			ash_s1  <= PROD_W'(st_a[j]) * PROD_W'(sin_k[63:32]);
			asl_s1  <= PROD_W'(st_a[j]) * PROD_W'(sin_k[31:0]);

			a_s2    <= a_s1;
			b_s2    <= b_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			mid_s2  <= mid_s1;
			tag_s2  <= tag_s1;
			diag_s2 <= diag_s1;
			bge_s2  <= bge_s1;
			lhs_s2  <= {bch_s1, 32'd0} + SUM_W'(bcl_s1);
			rhs_s2  <= {ash_s1, 32'd0} + SUM_W'(asl_s1);

			tag_s3  <= tag_s2;
			if (lo_s2 < hi_s2 && beyond) begin
				lo_s3 <= mid_s2;
			end else begin
				lo_s3 <= lo_s2;
			end
			if (lo_s2 < hi_s2 && !beyond) begin
				hi_s3 <= mid_s2 - DEG_W'(1);
			end else begin
				hi_s3 <= hi_s2;
			end
		end

		if (j < SEARCH_STEPS - 1) begin : g_fwd
			logic [MAG_W-1:0] a_s3, b_s3;
			always_ff @(posedge clk) begin
				a_s3 <= a_s2;
				b_s3 <= b_s2;
			end
			assign st_a[j+1] = a_s3;
			assign st_b[j+1] = b_s3;
		end

		assign st_vld[j+1] = vld_s3;
		assign st_lo[j+1]  = lo_s3;
		assign st_hi[j+1]  = hi_s3;
		assign st_tag[j+1] = tag_s3;
	end

	// quadrant base plus degree within the quadrant
	logic [ANGLE_W-1:0] quad_base;
	logic               out_vld_q;
	logic [ANGLE_W-1:0] angle_q;

	always_comb begin
		unique case (st_tag[SEARCH_STEPS].quad)
			QUAD_I:   quad_base = ANGLE_W'(0);
			QUAD_II:  quad_base = ANGLE_W'(90);
			QUAD_III: quad_base = ANGLE_W'(180);
			QUAD_IV:  quad_base = ANGLE_W'(270);
			default:  quad_base = ANGLE_W'(0);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= st_vld[SEARCH_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= st_tag[SEARCH_STEPS].zero ? '0
			: quad_base + ANGLE_W'(st_lo[SEARCH_STEPS]);
	end

	assign out_vld   = out_vld_q;
	assign out_angle = angle_q;

endmodule

/* rtl/cartesian_to_polar_degrees.sv */
// cartesian to polar in whole degrees, fully pipelined
// throughput: one transaction per cycle, busy is never raised
// done rises once the radius and angle paths, padded to equal depth, have passed the output register
// the receiver cannot stall; every result shows for exactly one cycle with done
// reset (arst_n low): pipeline emptied, center_x and center_y cleared to 0
`timescale 1ns / 1ps
module cartesian_to_polar_degrees import cpd_pkg::*; #(
	parameter int COORD_BITS = CPD_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         cfg_we,
	input  logic [REG_IDX_W-1:0]         cfg_idx,
	input  logic [COORD_BITS-1:0]        cfg_wdata,
	output logic                         done,
	output logic [RADIUS_W-1:0]          radius,
	output logic [ANGLE_W-1:0]           angle_deg
);

	// widths that follow from the coordinate width
	localparam int DIFF_W = COORD_BITS + 1;      // signed difference
	localparam int MAG_W  = COORD_BITS;          // magnitude of a difference
	localparam int SUM_W  = 2 * COORD_BITS + 1;  // sum of squares
	localparam int ROOT_W = COORD_BITS + 1;      // floor square root
	localparam int CMP_W  = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;

	// path latencies from the accepting edge, then padded to match
	localparam int RAD_LAT = 4 + ROOT_W;
	localparam int ANG_TOT = 2 + ANG_LAT;
	localparam int OUT_LAT = (RAD_LAT > ANG_TOT) ? RAD_LAT : ANG_TOT;
	localparam int RAD_PAD = OUT_LAT - RAD_LAT;
	localparam int ANG_PAD = OUT_LAT - ANG_TOT;

	// nothing holds the pipeline, a new point may enter every cycle
	assign busy = 1'b0;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	logic signed [COORD_BITS-1:0] center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: offsets from the center, y flipped so up is positive
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(point_x) - DIFF_W'(center_x_q);
		dy_s1 <= DIFF_W'(center_y_q) - DIFF_W'(point_y);
	end

	// stage 2: magnitudes, quadrant, and the operand pair for the angle search
	logic              dx_neg, dy_neg, dx_zero, dy_zero;
	logic [DIFF_W-1:0] dx_abs, dy_abs;
	logic [MAG_W-1:0]  ux, uy;
	quad_t             quad;

	assign dx_neg  = dx_s1[DIFF_W-1];
	assign dy_neg  = dy_s1[DIFF_W-1];
	assign dx_zero = dx_s1 == '0;
	assign dy_zero = dy_s1 == '0;
	assign dx_abs  = dx_neg ? -dx_s1 : dx_s1;
	assign dy_abs  = dy_neg ? -dy_s1 : dy_s1;
	assign ux      = dx_abs[MAG_W-1:0];
	assign uy      = dy_abs[MAG_W-1:0];

	// boundary directions fall into the quadrant that starts there
	always_comb begin
		if (!dx_neg && !dx_zero && !dy_neg) begin
			quad = QUAD_I;
		end else if ((dx_neg || dx_zero) && !dy_neg && !dy_zero) begin
			quad = QUAD_II;
		end else if (dx_neg && (dy_neg || dy_zero)) begin
			quad = QUAD_III;
		end else begin
			quad = QUAD_IV;
		end
	end

	logic             vld_s2;
	logic [MAG_W-1:0] ux_s2, uy_s2, a_s2, b_s2;
	ang_tag_t         tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// quadrants II and IV swap the pair so the search always runs 0..89 ccw
	always_ff @(posedge clk) begin
		ux_s2       <= ux;
		uy_s2       <= uy;
		a_s2        <= (quad == QUAD_I || quad == QUAD_III) ? ux : uy;
		b_s2        <= (quad == QUAD_I || quad == QUAD_III) ? uy : ux;
		tag_s2.quad <= quad;
		tag_s2.zero <= dx_zero && dy_zero;
	end

	// stage 3: squares
	logic             vld_s3;
	logic [SUM_W-1:0] sqx_s3, sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s3 <= SUM_W'(ux_s2) * SUM_W'(ux_s2);
		sqy_s3 <= SUM_W'(uy_s2) * SUM_W'(uy_s2);
	end

	// stage 4: squared distance
	logic             vld_s4;
	logic [SUM_W-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= sqx_s3 + sqy_s3;
	end

	// radius: one root bit per stage
	logic              rad_vld;
	logic [ROOT_W-1:0] rad_root;

	cpd_isqrt #(
		.IN_W   (SUM_W),
		.ROOT_W (ROOT_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_val   (sum_s4),
		.out_vld  (rad_vld),
		.out_root (rad_root)
	);

	// angle: binary search over the degree table, three stages per probe
	logic               ang_vld;
	logic [ANGLE_W-1:0] ang_deg;

	cpd_angle #(
		.MAG_W (MAG_W)
	) u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s2),
		.in_a      (a_s2),
		.in_b      (b_s2),
		.in_tag    (tag_s2),
		.out_vld   (ang_vld),
		.out_angle (ang_deg)
	);

	// align the two paths
	logic               rad_vld_d, ang_vld_d;
	logic [ROOT_W-1:0]  rad_root_d;
	logic [ANGLE_W-1:0] ang_deg_d;

	if (RAD_PAD > 0) begin : g_rad_pad
		logic              vld_q  [RAD_PAD];
		logic [ROOT_W-1:0] root_q [RAD_PAD];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < RAD_PAD; k++) begin
					vld_q[k] <= 1'b0;
				end
			end else begin
				vld_q[0] <= rad_vld;
				for (int k = 1; k < RAD_PAD; k++) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			root_q[0] <= rad_root;
			for (int k = 1; k < RAD_PAD; k++) begin
				root_q[k] <= root_q[k-1];
			end
		end

		assign rad_vld_d  = vld_q[RAD_PAD-1];
		assign rad_root_d = root_q[RAD_PAD-1];
	end else begin : g_rad_direct
		assign rad_vld_d  = rad_vld;
		assign rad_root_d = rad_root;
	end

	if (ANG_PAD > 0) begin : g_ang_pad
		logic               vld_q [ANG_PAD];
		logic [ANGLE_W-1:0] deg_q [ANG_PAD];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < ANG_PAD; k++) begin
					vld_q[k] <= 1'b0;
				end
			end else begin
				vld_q[0] <= ang_vld;
				for (int k = 1; k < ANG_PAD; k++) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			deg_q[0] <= ang_deg;
			for (int k = 1; k < ANG_PAD; k++) begin
				deg_q[k] <= deg_q[k-1];
			end
		end

		assign ang_vld_d = vld_q[ANG_PAD-1];
		assign ang_deg_d = deg_q[ANG_PAD-1];
	end else begin : g_ang_direct
		assign ang_vld_d = ang_vld;
		assign ang_deg_d = ang_deg;
	end

	// output register, radius clamped when the coordinates are wide
	logic                done_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [ANGLE_W-1:0]  angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rad_vld_d && ang_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		radius_q <= (CMP_W'(rad_root_d) > CMP_W'(RADIUS_MAX)) ? RADIUS_MAX
			: RADIUS_W'(rad_root_d);
		angle_q  <= ang_deg_d;
	end

	assign done      = done_q;
	assign radius    = radius_q;
	assign angle_deg = angle_q;

endmodule

/* dv/tb_cartesian_to_polar_degrees.sv */
`timescale 1ns / 1ps
module tb_cartesian_to_polar_degrees;
	import cpd_pkg::*;

	localparam int          CB          = CPD_COORD_BITS;
	localparam int          CYCLE_LIMIT = 200_000;
	// tail longer than the pipeline depth, keep some margin after the last result
	localparam int          TAIL_CYCLES = 40;
	localparam int          REPORT_MAX  = 10;
	localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;

	// one predicted transaction, the point is kept for messages
	typedef struct {
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
		logic [RADIUS_W-1:0]  radius;
		logic [ANGLE_W-1:0]   angle;
	} polar_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic signed [CB-1:0] point_x   = '0;
	logic signed [CB-1:0] point_y   = '0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_idx   = REG_CENTER_X;
	logic [CB-1:0]        cfg_wdata = '0;
	logic                 done;
	logic [RADIUS_W-1:0]  radius;
	logic [ANGLE_W-1:0]   angle_deg;

	// shadow of the center registers, as written last
	logic signed [CB-1:0] center_x_q = '0;
	logic signed [CB-1:0] center_y_q = '0;

	// sin / cos of whole degrees in q62
	logic [63:0] deg_sin [DEG_N];
	logic [63:0] deg_cos [DEG_N];

	polar_t pending_polar [$];
	int     mismatches  = 0;
	int     cycle_count = 0;

	cartesian_to_polar_degrees #(
		.COORD_BITS(CB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.point_x  (point_x),
		.point_y  (point_y),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.radius   (radius),
		.angle_deg(angle_deg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// q62 times q62, truncated back to q62
	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// one-degree step from a short series, then rotate step by step
	function automatic void build_degree_rom();
		logic [63:0] step, s2, s3, s4, s5, s6, s7, s8, sin1, cos1;
		int          k;
		step = 64'h3243F6A8885A308D / 64'd45;
		s2   = q62_product(step, step);
		s3   = q62_product(s2, step);
		s4   = q62_product(s2, s2);
		s5   = q62_product(s3, s2);
		s6   = q62_product(s4, s2);
		s7   = q62_product(s5, s2);
		s8   = q62_product(s4, s4);
		sin1 = step - s3 / 64'd6 + s5 / 64'd120 - s7 / 64'd5040;
		cos1 = Q62_ONE - s2 / 64'd2 + s4 / 64'd24 - s6 / 64'd720 + s8 / 64'd40320;
		deg_sin[0] = 64'd0;
		deg_cos[0] = Q62_ONE;
		for (k = 0; k < DEG_N - 1; k++) begin
			deg_cos[k+1] = q62_product(deg_cos[k], cos1) - q62_product(deg_sin[k], sin1);
			deg_sin[k+1] = q62_product(deg_sin[k], cos1) + q62_product(deg_cos[k], sin1);
		end
	endfunction

	// floor of the square root, one result bit at a time
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r, c;
		int              i;
		r = 0;
		for (i = RADIUS_W; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if (c * c <= v) begin
				r = c;
			end
		end
		return r;
	endfunction

	// first-quadrant vector (along, across) lies at or past k degrees
	function automatic bit reaches_degree(input int k, input longint unsigned along,
			input longint unsigned across);
		logic [127:0] lhs, rhs;
		if (k == 0) begin
			return 1'b1;
		end
		// diagonal is exact, no table needed
		if (k == int'(DEG_DIAG)) begin
			return across >= along;
		end
		lhs = {64'd0, across} * {64'd0, deg_cos[k]};
		rhs = {64'd0, along} * {64'd0, deg_sin[k]};
		return lhs >= rhs;
	endfunction

	function automatic polar_t predict_polar(input logic signed [CB-1:0] px,
			input logic signed [CB-1:0] py);
		polar_t          res;
		longint          dx, dy;
		longint unsigned ux, uy, root, along, across;
		quad_t           quad;
		int              lo, hi, mid;
		res.px = px;
		res.py = py;
		// screen y grows downward, so dy is taken from the center
		dx = longint'(px) - longint'(center_x_q);
		dy = longint'(center_y_q) - longint'(py);
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		root = floor_root(ux * ux + uy * uy);
		res.radius = (root > RADIUS_MAX) ? RADIUS_MAX : root[RADIUS_W-1:0];
		res.angle  = '0;
		// point on the center
		if (dx == 0 && dy == 0) begin
			res.radius = '0;
			return res;
		end
		// quadrant from the signs, axes belong to the quadrant they open
		if (dx > 0 && dy >= 0) begin
			quad = QUAD_I;   along = ux; across = uy;
		end else if (dx <= 0 && dy > 0) begin
			quad = QUAD_II;  along = uy; across = ux;
		end else if (dx < 0 && dy <= 0) begin
			quad = QUAD_III; along = ux; across = uy;
		end else begin
			quad = QUAD_IV;  along = uy; across = ux;
		end
		// largest degree that the vector reaches
		lo = 0;
		hi = int'(DEG_LAST);
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (reaches_degree(mid, along, across)) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		res.angle = ANGLE_W'(int'(quad) * 90 + lo);
		return res;
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// results cannot be held off, so every done cycle is one transaction
	always @(posedge clk) begin : check_result
		polar_t want;
		if (arst_n && done) begin
			if (pending_polar.size() == 0) begin
				note_failure($sformatf("unexpected result radius %0d angle %0d",
					radius, angle_deg));
			end else begin
				want = pending_polar.pop_front();
				if (radius !== want.radius) begin
					note_failure($sformatf("point (%0d,%0d) radius %0d expected %0d",
						want.px, want.py, radius, want.radius));
				end
				if (angle_deg !== want.angle) begin
					note_failure($sformatf("point (%0d,%0d) angle %0d expected %0d",
						want.px, want.py, angle_deg, want.angle));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------

	// start stays high when the next transaction follows at once
	task automatic send_point(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py);
		start   <= 1'b1;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_polar.push_back(predict_polar(px, py));
	endtask

	// idle step: start low and junk on the point ports
	task automatic idle_cycle();
		start   <= 1'b0;
		point_x <= CB'($urandom);
		point_y <= CB'($urandom);
		@(posedge clk);
	endtask

	// every point gives one result, so an empty queue means an empty pipeline
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_polar.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_center(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_CENTER_X;
		cfg_wdata <= cx;
		@(posedge clk);
		cfg_idx   <= REG_CENTER_Y;
		cfg_wdata <= cy;
		@(posedge clk);
		cfg_we     <= 1'b0;
		center_x_q = cx;
		center_y_q = cy;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// center at its reset value: origin, axes, diagonals, coordinate extremes
	task automatic test_reset_center();
		send_point(16'sd0, 16'sd0);
		send_point(16'sd1, 16'sd0);
		send_point(16'sd0, -16'sd1);
		send_point(-16'sd1, 16'sd0);
		send_point(16'sd0, 16'sd1);
		send_point(16'sd1, -16'sd1);
		send_point(-16'sd1, -16'sd1);
		send_point(-16'sd1, 16'sd1);
		send_point(16'sd1, 16'sd1);
		send_point(16'sh7fff, 16'sh8000);
		send_point(16'sh8000, 16'sh7fff);
		send_point(16'sh8000, 16'sh8000);
		send_point(16'sh7fff, 16'sh7fff);
		wait_drained();
	endtask

	// center in opposite corners: widest offsets, axes and point on the center
	task automatic test_extreme_centers();
		write_center(16'sh8000, 16'sh7fff);
		send_point(16'sh7fff, 16'sh8000);
		send_point(16'sh8000, 16'sh7fff);
		send_point(16'sh7fff, 16'sh7fff);
		send_point(16'sh8000, 16'sh8000);
		wait_drained();
		write_center(16'sh7fff, 16'sh8000);
		send_point(16'sh8000, 16'sh7fff);
		send_point(16'sh7fff, 16'sh8000);
		send_point(16'sh8000, 16'sh8000);
		send_point(16'sh7fff, 16'sh7fff);
		wait_drained();
	endtask

	// random points in segments, each with its own center and idle rate
	task automatic test_random_points();
		int                   seg, n, kind, len, k, idle_pct, dx, dy;
		logic signed [CB-1:0] cx, cy, px, py;
		real                  phi;
		for (seg = 0; seg < 6; seg++) begin
			case (seg)
				1: begin
					cx = 16'sh8000; cy = 16'sh8000;
				end
				4: begin
					cx = 16'sh7fff; cy = 16'sh7fff;
				end
				2, 5: begin
					cx = CB'($urandom);
					cy = CB'($urandom);
				end
				default: begin
					// centers near the middle keep most offsets unwrapped
					cx = CB'(int'($urandom_range(0, 2000)) - 1000);
					cy = CB'(int'($urandom_range(0, 2000)) - 1000);
				end
			endcase
			wait_drained();
			write_center(cx, cy);
			// back to back, mostly idle, lightly idle
			idle_pct = (seg % 3 == 0) ? 0 : ((seg % 3 == 1) ? 78 : 14);
			for (n = 0; n < 150; n++) begin
				while ($urandom_range(0, 99) < idle_pct) begin
					idle_cycle();
				end
				kind = $urandom_range(0, 9);
				dx   = 0;
				dy   = 0;
				case (kind)
					0, 1, 2: begin
						// anywhere in the coordinate range
						dx = int'(CB'($urandom)) - int'(cx);
						dy = int'(cy) - int'(CB'($urandom));
					end
					3, 4: begin
						// short vectors, many degree steps fall between pixels
						dx = int'($urandom_range(0, 400)) - 200;
						dy = int'($urandom_range(0, 400)) - 200;
					end
					5: begin
						// on an axis
						len = $urandom_range(1, 32767);
						case ($urandom_range(0, 3))
							0: dx = len;
							1: dy = len;
							2: dx = -len;
							default: dy = -len;
						endcase
					end
					6: begin
						// on a diagonal
						len = $urandom_range(1, 32767);
						dx  = $urandom_range(0, 1) ? len : -len;
						dy  = $urandom_range(0, 1) ? len : -len;
					end
					7: begin
						// right on the center
					end
					default: begin
						// hugging a whole-degree ray, either side
						k   = $urandom_range(0, 359);
						phi = k * 3.14159265358979 / 180.0;
						len = $urandom_range(8, 40000);
						dx  = $rtoi(len * $cos(phi)) + int'($urandom_range(0, 2)) - 1;
						dy  = $rtoi(len * $sin(phi)) + int'($urandom_range(0, 2)) - 1;
					end
				endcase
				// offsets past the range simply wrap to another point
				px = CB'(int'(cx) + dx);
				py = CB'(int'(cy) - dy);
				send_point(px, py);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// sequence and end of run
	// ---------------------------------------------------------------

	initial begin
		build_degree_rom();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_center();
		test_extreme_centers();
		test_random_points();
		wait_drained();
		// catch any result beyond the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_polar.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_polar.size()));
		end
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hang guard
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
